>>> src/srtc_pkg.sv
// Shared types and constants of the segment region table checker.
package srtc_pkg;

	localparam int VALUE_W = 28;
	localparam int SEG_W   = 8;
	localparam int PID_W   = 8;
	localparam int CMD_W   = 2;

	typedef enum logic [CMD_W-1:0] {
		CMD_ALLOC  = 2'd0,
		CMD_ADD    = 2'd1,
		CMD_ACCESS = 2'd2,
		CMD_CLEAR  = 2'd3
	} cmd_t;

	typedef struct packed {
		logic vld;
		cmd_t cmd;
		logic verdict;
		logic placed;
	} ctl_t;

endpackage

>>> src/srtc_decode.sv
// Three-stage split of the packed command value into segment, base and size.
module srtc_decode #(
	parameter int OFFSET_RADIX  = 1000,
	parameter int SEGMENT_RADIX = 1000000,
	parameter int OFS_W         = 10
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_vld,
	input  srtc_pkg::cmd_t                in_cmd,
	input  logic [srtc_pkg::VALUE_W-1:0]  in_value,
	input  logic [srtc_pkg::PID_W-1:0]    in_pid,
	output srtc_pkg::ctl_t                ctl_out,
	output logic [srtc_pkg::SEG_W-1:0]    seg_out,
	output logic [srtc_pkg::PID_W-1:0]    pid_out,
	output logic [OFS_W-1:0]              base_out,
	output logic [OFS_W-1:0]              size_out
);
	import srtc_pkg::*;

	localparam int MUL_W  = VALUE_W + 1;
	localparam int PROD_W = VALUE_W + MUL_W;
	localparam int OFS_SH = VALUE_W + $clog2(OFFSET_RADIX);
	localparam int SEG_SH = VALUE_W + $clog2(SEGMENT_RADIX);
	localparam longint unsigned OFS_M_FULL =
		((longint'(1) << OFS_SH) + longint'(OFFSET_RADIX) - 1) / longint'(OFFSET_RADIX);
	localparam longint unsigned SEG_M_FULL =
		((longint'(1) << SEG_SH) + longint'(SEGMENT_RADIX) - 1) / longint'(SEGMENT_RADIX);
	localparam logic [MUL_W-1:0] OFS_M = MUL_W'(OFS_M_FULL);
	localparam logic [MUL_W-1:0] SEG_M = MUL_W'(SEG_M_FULL);

	logic [PROD_W-1:0]  ofs_prod;
	logic [PROD_W-1:0]  seg_prod;
	logic [PROD_W-1:0]  q2_prod;
	logic [PROD_W-1:0]  rem_prod;

	logic               vld_s1, vld_s2, vld_s3;
	cmd_t               cmd_s1, cmd_s2, cmd_s3;
	logic [PID_W-1:0]   pid_s1, pid_s2, pid_s3;
	logic [SEG_W-1:0]   seg_s1, seg_s2, seg_s3;
	logic [VALUE_W-1:0] value_s1;
	logic [VALUE_W-1:0] q1_s1;
	logic [OFS_W-1:0]   size_s2, size_s3;
	logic [OFS_W-1:0]   q1lo_s2;
	logic [OFS_W-1:0]   q2lo_s2;
	logic [OFS_W-1:0]   base_s3;

	assign ofs_prod = PROD_W'(in_value) * PROD_W'(OFS_M);
	assign seg_prod = PROD_W'(in_value) * PROD_W'(SEG_M);
	assign q2_prod  = PROD_W'(q1_s1) * PROD_W'(OFS_M);
	assign rem_prod = PROD_W'(q1_s1) * PROD_W'(OFFSET_RADIX);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		cmd_s1   <= in_cmd;
		pid_s1   <= in_pid;
		value_s1 <= in_value;
		q1_s1    <= VALUE_W'(ofs_prod >> OFS_SH);
		seg_s1   <= SEG_W'(seg_prod >> SEG_SH);

		cmd_s2   <= cmd_s1;
		pid_s2   <= pid_s1;
		seg_s2   <= seg_s1;
		size_s2  <= OFS_W'(value_s1 - VALUE_W'(rem_prod));
		q1lo_s2  <= OFS_W'(q1_s1);
		q2lo_s2  <= OFS_W'(q2_prod >> OFS_SH);

		cmd_s3   <= cmd_s2;
		pid_s3   <= pid_s2;
		seg_s3   <= seg_s2;
		size_s3  <= size_s2;
		base_s3  <= q1lo_s2 - OFS_W'(q2lo_s2 * OFS_W'(OFFSET_RADIX));
	end

	always_comb begin
		ctl_out.vld     = vld_s3;
		ctl_out.cmd     = cmd_s3;
		ctl_out.verdict = (cmd_s3 == CMD_ALLOC);
		ctl_out.placed  = 1'b0;
	end

	assign seg_out  = seg_s3;
	assign pid_out  = pid_s3;
	assign base_out = base_s3;
	assign size_out = size_s3;

endmodule

>>> src/srtc_cell.sv
// One table entry: checks the passing request against its region and hands it on.
module srtc_cell #(
	parameter int OFS_W = 10
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  srtc_pkg::ctl_t              ctl_in,
	input  logic [srtc_pkg::SEG_W-1:0]  seg_in,
	input  logic [srtc_pkg::PID_W-1:0]  pid_in,
	input  logic [OFS_W-1:0]            base_in,
	input  logic [OFS_W-1:0]            size_in,
	output srtc_pkg::ctl_t              ctl_out,
	output logic [srtc_pkg::SEG_W-1:0]  seg_out,
	output logic [srtc_pkg::PID_W-1:0]  pid_out,
	output logic [OFS_W-1:0]            base_out,
	output logic [OFS_W-1:0]            size_out
);
	import srtc_pkg::*;

	logic             ent_vld_q;
	logic [SEG_W-1:0] ent_seg_q;
	logic [PID_W-1:0] ent_owner_q;
	logic [OFS_W-1:0] ent_base_q;
	logic [OFS_W-1:0] ent_size_q;

	ctl_t             ctl_q;
	logic [SEG_W-1:0] seg_q;
	logic [PID_W-1:0] pid_q;
	logic [OFS_W-1:0] base_q;
	logic [OFS_W-1:0] size_q;

	logic [OFS_W:0]   ent_end;
	logic [OFS_W:0]   req_end;
	logic             seg_hit;
	logic             overlap;
	logic             contain;
	logic             take;
	ctl_t             ctl_nxt;

	always_comb begin
		ent_end = {1'b0, ent_base_q} + {1'b0, ent_size_q};
		req_end = {1'b0, base_in} + {1'b0, size_in};
		seg_hit = ent_vld_q && (ent_seg_q == seg_in);
		overlap = seg_hit && ({1'b0, base_in} < ent_end) && ({1'b0, ent_base_q} < req_end);
		contain = seg_hit && (ent_owner_q == pid_in) && (base_in >= ent_base_q)
			&& (req_end <= ent_end);
		take    = ctl_in.vld && (ctl_in.cmd == CMD_ADD) && !ent_vld_q && !ctl_in.placed;
		ctl_nxt = ctl_in;
		unique case (ctl_in.cmd)
			CMD_ALLOC: begin
				if (overlap) begin
					ctl_nxt.verdict = 1'b0;
				end
			end
			CMD_ADD: begin
				if (!ent_vld_q) begin
					ctl_nxt.placed = 1'b1;
				end
			end
			CMD_ACCESS: begin
				if (contain) begin
					ctl_nxt.verdict = 1'b1;
				end
			end
			CMD_CLEAR: begin
				ctl_nxt = ctl_in;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ent_vld_q <= 1'b0;
			ctl_q     <= '0;
		end else begin
			ctl_q <= ctl_nxt;
			if (ctl_in.vld && (ctl_in.cmd == CMD_CLEAR)) begin
				ent_vld_q <= 1'b0;
			end else if (take) begin
				ent_vld_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		seg_q  <= seg_in;
		pid_q  <= pid_in;
		base_q <= base_in;
		size_q <= size_in;
		if (take) begin
			ent_seg_q   <= seg_in;
			ent_owner_q <= pid_in;
			ent_base_q  <= base_in;
			ent_size_q  <= size_in;
		end
	end

	assign ctl_out  = ctl_q;
	assign seg_out  = seg_q;
	assign pid_out  = pid_q;
	assign base_out = base_q;
	assign size_out = size_q;

endmodule

>>> src/segment_region_table_checker.sv
// Top level: decode pipeline, row of table cells and the result beat registers.
// From an accepted beat to m_tvalid the request passes three decode stages, one
// register per table cell, one result stage and the output register.
// Only one beat is in flight at a time; the request walks the cell row.
// s_tready rises again once the result has moved into the output register.
// Reset (arst_n low) empties the table and drops any request and result in flight.
module segment_region_table_checker #(
	parameter int TABLE_DEPTH   = 16,
	parameter int OFFSET_RADIX  = 1000,
	parameter int SEGMENT_RADIX = 1000000
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,  // comm_value[27:0], process_id[35:28], zero [39:36]
	input  logic [1:0]  s_tuser,  // cmd[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata   // verdict[0], table_full[1], zero [7:2]
);
	import srtc_pkg::*;

	localparam int OFS_W = $clog2(OFFSET_RADIX);

	ctl_t             ctl_c  [TABLE_DEPTH+1];
	logic [SEG_W-1:0] seg_c  [TABLE_DEPTH+1];
	logic [PID_W-1:0] pid_c  [TABLE_DEPTH+1];
	logic [OFS_W-1:0] base_c [TABLE_DEPTH+1];
	logic [OFS_W-1:0] size_c [TABLE_DEPTH+1];
	logic [TABLE_DEPTH-1:0] chain_vld;

	logic busy_q;
	logic pend_vld_q;
	logic pend_verdict_q;
	logic pend_full_q;
	logic out_vld_q;
	logic out_verdict_q;
	logic out_full_q;
	logic in_fire;
	logic pend_move;

	assign s_tready  = !busy_q;
	assign in_fire   = s_tvalid && !busy_q;
	assign pend_move = pend_vld_q && (!out_vld_q || m_tready);

	srtc_decode #(
		.OFFSET_RADIX  (OFFSET_RADIX),
		.SEGMENT_RADIX (SEGMENT_RADIX),
		.OFS_W         (OFS_W)
	) u_decode (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_vld   (in_fire),
		.in_cmd   (cmd_t'(s_tuser)),
		.in_value (s_tdata[VALUE_W-1:0]),
		.in_pid   (s_tdata[VALUE_W +: PID_W]),
		.ctl_out  (ctl_c[0]),
		.seg_out  (seg_c[0]),
		.pid_out  (pid_c[0]),
		.base_out (base_c[0]),
		.size_out (size_c[0])
	);

	for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
		srtc_cell #(
			.OFS_W (OFS_W)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl_in   (ctl_c[i]),
			.seg_in   (seg_c[i]),
			.pid_in   (pid_c[i]),
			.base_in  (base_c[i]),
			.size_in  (size_c[i]),
			.ctl_out  (ctl_c[i+1]),
			.seg_out  (seg_c[i+1]),
			.pid_out  (pid_c[i+1]),
			.base_out (base_c[i+1]),
			.size_out (size_c[i+1])
		);
		assign chain_vld[i] = ctl_c[i+1].vld;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q     <= 1'b0;
			pend_vld_q <= 1'b0;
			out_vld_q  <= 1'b0;
		end else begin
			if (in_fire) begin
				busy_q <= 1'b1;
			end else if (pend_move) begin
				busy_q <= 1'b0;
			end
			if (ctl_c[TABLE_DEPTH].vld) begin
				pend_vld_q <= 1'b1;
			end else if (pend_move) begin
				pend_vld_q <= 1'b0;
			end
			if (pend_move) begin
				out_vld_q <= 1'b1;
			end else if (m_tready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl_c[TABLE_DEPTH].vld) begin
			pend_verdict_q <= ctl_c[TABLE_DEPTH].verdict;
			pend_full_q    <= (ctl_c[TABLE_DEPTH].cmd == CMD_ADD) && !ctl_c[TABLE_DEPTH].placed;
		end
		if (pend_move) begin
			out_verdict_q <= pend_verdict_q;
			out_full_q    <= pend_full_q;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = {6'd0, out_full_q, out_verdict_q};

`ifndef SYNTHESIS
	a_one_in_row: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({chain_vld, pend_vld_q}))
		else $error("more than one request in the cell row");
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> !s_tready)
		else $error("input ready after accepting a beat");
	a_row_needs_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(chain_vld != '0 || pend_vld_q) |-> busy_q)
		else $error("request in flight while idle");
	a_flags_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tdata[0] && m_tdata[1]))
		else $error("verdict and table_full both set");
	a_pend_moves: assert property (@(posedge clk) disable iff (!arst_n)
		(pend_vld_q && !out_vld_q) |=> (out_vld_q && !pend_vld_q))
		else $error("pending result not moved to output register");
`endif

endmodule

>>> verif/segment_region_table_checker_test.sv
// Testbench of the segment region table checker, scored against a behavioral table.
`timescale 1ns / 1ps

module segment_region_table_checker_test;
	import srtc_pkg::*;

	localparam int TABLE_DEPTH   = 16;
	localparam int OFFSET_RADIX  = 1000;
	localparam int SEGMENT_RADIX = 1000000;
	localparam int LATENCY       = TABLE_DEPTH + 5;
	localparam int RANDOM_ITEMS  = 660;
	localparam int CYCLE_LIMIT   = 400000;
	localparam logic [VALUE_W-1:0] VALUE_MAX = '1;

	typedef struct packed {
		logic verdict;
		logic full;
	} reply_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [39:0] s_tdata = '0;   // comm_value[27:0], process_id[35:28], zero [39:36]
	logic [1:0] s_tuser = CMD_ALLOC;   // cmd[1:0]
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [7:0] m_tdata;   // verdict[0], table_full[1], zero [7:2]

	logic tbl_valid [TABLE_DEPTH] = '{default: 1'b0};
	logic [SEG_W-1:0] tbl_seg [TABLE_DEPTH];
	logic [9:0] tbl_base [TABLE_DEPTH];
	logic [9:0] tbl_size [TABLE_DEPTH];
	logic [PID_W-1:0] tbl_owner [TABLE_DEPTH];
	int tbl_count = 0;

	reply_t expected_replies [$];
	logic [VALUE_W-1:0] placed_value [$];
	logic [PID_W-1:0] placed_pid [$];
	int mismatch_count = 0;
	int cycle_count = 0;
	int hold_request = 0;
	int stall_left = 0;
	bit steady = 1'b0;

	segment_region_table_checker #(
		.TABLE_DEPTH(TABLE_DEPTH),
		.OFFSET_RADIX(OFFSET_RADIX),
		.SEGMENT_RADIX(SEGMENT_RADIX)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	always #6 clk = ~clk;

	function automatic reply_t table_reply(cmd_t cmd, logic [VALUE_W-1:0] value,
			logic [PID_W-1:0] pid);
		int unsigned v, b, s, eb, es;
		logic [SEG_W-1:0] seg;
		reply_t r;
		int i;
		v = value;
		s = v % OFFSET_RADIX;
		b = (v / OFFSET_RADIX) % OFFSET_RADIX;
		seg = SEG_W'(v / SEGMENT_RADIX);
		r = '0;
		case (cmd)
			CMD_ALLOC: begin
				r.verdict = 1'b1;
				for (i = 0; i < TABLE_DEPTH; i++) begin
					eb = tbl_base[i];
					es = tbl_size[i];
					if (tbl_valid[i] && tbl_seg[i] == seg && b < eb + es && eb < b + s)
						r.verdict = 1'b0;
				end
			end
			CMD_ADD: begin
				if (tbl_count >= TABLE_DEPTH) begin
					r.full = 1'b1;
				end else begin
					tbl_valid[tbl_count] = 1'b1;
					tbl_seg[tbl_count] = seg;
					tbl_base[tbl_count] = 10'(b);
					tbl_size[tbl_count] = 10'(s);
					tbl_owner[tbl_count] = pid;
					tbl_count++;
				end
			end
			CMD_ACCESS: begin
				for (i = 0; i < TABLE_DEPTH; i++) begin
					eb = tbl_base[i];
					es = tbl_size[i];
					if (tbl_valid[i] && tbl_seg[i] == seg && tbl_owner[i] == pid &&
							b >= eb && b + s <= eb + es)
						r.verdict = 1'b1;
				end
			end
			default: begin
				for (i = 0; i < TABLE_DEPTH; i++)
					tbl_valid[i] = 1'b0;
				tbl_count = 0;
			end
		endcase
		return r;
	endfunction

	task automatic note_mismatch(string what, int want, int got);
		mismatch_count++;
		if (mismatch_count <= 10)
			$display("mismatch %0d at %0t: %s expected %0d actual %0d",
				mismatch_count, $realtime, what, want, got);
	endtask

	always @(posedge clk) begin
		reply_t want;
		if (arst_n) begin
			if (s_tvalid && s_tready)
				expected_replies.push_back(table_reply(cmd_t'(s_tuser), s_tdata[27:0],
					s_tdata[35:28]));
			if (m_tvalid && m_tready) begin
				if (expected_replies.size() == 0) begin
					note_mismatch("result beat with nothing pending, m_tdata", -1, int'(m_tdata));
				end else begin
					want = expected_replies.pop_front();
					if (m_tdata[0] !== want.verdict)
						note_mismatch("verdict", want.verdict, int'(m_tdata[0]));
					if (m_tdata[1] !== want.full)
						note_mismatch("table_full", want.full, int'(m_tdata[1]));
				end
			end
		end
	end

	function automatic int idle_length();
		if ($urandom_range(0, 99) < 85)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	always @(posedge clk) begin
		if (hold_request != 0) begin
			stall_left = hold_request;
			hold_request = 0;
		end
		if (stall_left > 0) begin
			stall_left--;
			m_tready <= 1'b0;
		end else if (!steady && $urandom_range(0, 99) < 20) begin
			stall_left = idle_length() - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	task automatic send_request(cmd_t cmd, logic [VALUE_W-1:0] value, logic [PID_W-1:0] pid);
		int gap;
		gap = (!steady && $urandom_range(0, 99) < 40) ? idle_length() : 0;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= cmd;
		s_tdata <= {4'b0, pid, value};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
	endtask

	function automatic logic [VALUE_W-1:0] pack_region(int seg, int base, int size);
		return VALUE_W'(seg * SEGMENT_RADIX + base * OFFSET_RADIX + size);
	endfunction

	function automatic int nudge(int x);
		int y;
		y = x + $urandom_range(0, 6) - 3;
		return y < 0 ? 0 : (y > OFFSET_RADIX - 1 ? OFFSET_RADIX - 1 : y);
	endfunction

	task automatic send_random_request();
		cmd_t cmd;
		logic [VALUE_W-1:0] value;
		logic [PID_W-1:0] pid;
		int k, seg, base, size, roll;
		roll = $urandom_range(0, 99);
		cmd = roll < 30 ? CMD_ALLOC : roll < 60 ? CMD_ADD : roll < 96 ? CMD_ACCESS : CMD_CLEAR;
		seg = $urandom_range(0, 3);
		base = $urandom_range(0, OFFSET_RADIX - 1);
		size = $urandom_range(0, 60);
		pid = PID_W'($urandom_range(1, 3));
		roll = $urandom_range(0, 99);
		if (roll < 10) begin
			value = VALUE_W'($urandom_range(0, VALUE_MAX));
			pid = PID_W'($urandom);
		end else if (roll < 15) begin
			value = pack_region($urandom_range(256, 267), base, size);
		end else if (cmd != CMD_ADD && placed_value.size() != 0 && roll < 80) begin
			k = $urandom_range(0, placed_value.size() - 1);
			seg = placed_value[k] / SEGMENT_RADIX;
			base = nudge((placed_value[k] / OFFSET_RADIX) % OFFSET_RADIX);
			size = nudge(placed_value[k] % OFFSET_RADIX);
			value = pack_region(seg, base, size);
			if ($urandom_range(0, 4) != 0)
				pid = placed_pid[k];
		end else begin
			value = pack_region(seg, base, size);
		end
		if (cmd == CMD_ADD && placed_value.size() < TABLE_DEPTH) begin
			placed_value.push_back(value);
			placed_pid.push_back(pid);
		end else if (cmd == CMD_CLEAR) begin
			placed_value.delete();
			placed_pid.delete();
		end
		send_request(cmd, value, pid);
	endtask

	task automatic test_empty_table();
		send_request(CMD_ALLOC, pack_region(5, 100, 50), 8'd7);
		send_request(CMD_ACCESS, pack_region(5, 100, 50), 8'd7);
		send_request(CMD_CLEAR, '0, '0);
	endtask

	task automatic test_fill_table();
		int i;
		send_request(CMD_ADD, pack_region(5, 100, 50), 8'd7);
		send_request(CMD_ADD, VALUE_MAX, 8'd0);
		send_request(CMD_ADD, pack_region(255, 999, 999), 8'd255);
		send_request(CMD_ADD, '0, 8'd0);
		for (i = 4; i < TABLE_DEPTH; i++)
			send_request(CMD_ADD, pack_region(i, i * 10, 20), PID_W'(i));
		send_request(CMD_ADD, pack_region(5, 500, 10), 8'd7);
	endtask

	task automatic test_alloc_overlap();
		send_request(CMD_ALLOC, pack_region(5, 149, 1), 8'd0);
		send_request(CMD_ALLOC, pack_region(5, 150, 10), 8'd0);
		send_request(CMD_ALLOC, pack_region(5, 90, 10), 8'd0);
		send_request(CMD_ALLOC, pack_region(5, 120, 0), 8'd0);
	endtask

	task automatic test_access_rights();
		send_request(CMD_ACCESS, pack_region(5, 100, 50), 8'd7);
		send_request(CMD_ACCESS, pack_region(5, 100, 50), 8'd8);
		send_request(CMD_ACCESS, pack_region(5, 150, 0), 8'd7);
		send_request(CMD_ACCESS, VALUE_MAX, 8'd0);
	endtask

	task automatic test_clear_table();
		send_request(CMD_CLEAR, VALUE_MAX, 8'hFF);
		send_request(CMD_ALLOC, pack_region(5, 100, 50), 8'd7);
	endtask

	task automatic test_receiver_hold();
		int i;
		steady = 1'b1;
		hold_request = 500;
		for (i = 0; i < 8; i++)
			send_random_request();
		steady = 1'b0;
	endtask

	task automatic test_random_traffic();
		int i;
		steady = 1'b1;
		for (i = 0; i < RANDOM_ITEMS; i++) begin
			if (i == 80)
				steady = 1'b0;
			send_random_request();
		end
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_table();
		test_fill_table();
		test_alloc_overlap();
		test_access_rights();
		test_clear_table();
		test_receiver_hold();
		test_random_traffic();
		s_tvalid <= 1'b0;
		while (expected_replies.size() != 0) @(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);
		if (mismatch_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
